FILE: design/ptfi_pkg.sv
// Package for the phase table foot interpolator: table geometry, entry and
// side-band types, register indexes and the 32-bit saturation helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ptfi_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int BANK_DEPTH  = TABLE_DEPTH / 2;
	localparam int BANK_AW     = ADDR_W - 1;
	localparam int PHASE_W     = 16;
	localparam int INDEX_W     = 10;
	localparam int NUM_LANES   = 4;
	localparam int NUM_STAGES  = 8;
	localparam int CFG_IDX_W   = 3;

	// Lanes of an entry that carry 32-bit signed Q16.16 values.
	localparam int LANE_LX = 0;
	localparam int LANE_LZ = 1;
	localparam int LANE_SX = 2;
	localparam int LANE_SZ = 3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_MOUNT_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MOUNT_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MOUNT_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_YAW_COS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_YAW_SIN = 3'd4;

	localparam logic signed [15:0] YAW_COS_RESET = 16'sd16384;

	typedef struct packed {
		logic [NUM_LANES-1:0][31:0] lane;
		logic [15:0]                conf;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [PHASE_W-1:0] frac;
		logic signed [31:0] rate;
		logic               rdy;
	} side_t;

	typedef struct packed {
		logic signed [31:0] mount_x;
		logic signed [31:0] mount_y;
		logic signed [31:0] mount_z;
		logic signed [15:0] yaw_cos;
		logic signed [15:0] yaw_sin;
	} cfg_t;

	// One load enable per pipeline stage, stage 1 in bit 0.
	typedef struct packed {
		logic [NUM_STAGES-1:0] load;
	} pipe_ctrl_t;

	localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
	localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > S32_MAX) begin
			r = 32'sh7fffffff;
		end else if (v < S32_MIN) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: design/ptfi_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ptfi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: design/ptfi_table.sv
// Foot table storage: even and odd entry banks so that two neighboring entries
// are read in the same cycle, plus the table-loaded flag. Uses ptfi_pkg and ptfi_ram.
`timescale 1ns / 1ps
`default_nettype none

module ptfi_table (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire ptfi_pkg::pipe_ctrl_t        ctrl,
	input  wire logic                        wr_en,
	input  wire logic [ptfi_pkg::ADDR_W-1:0] wr_index,
	input  wire ptfi_pkg::entry_t            wr_entry,
	input  wire logic                        rd_en,
	input  wire logic [ptfi_pkg::ADDR_W-1:0] rd_index,
	output ptfi_pkg::entry_t                 ent0,
	output ptfi_pkg::entry_t                 ent1,
	output logic                             loaded
);
	import ptfi_pkg::*;

	logic               we_even, we_odd;
	logic [BANK_AW-1:0] ra_even, ra_odd, ra_half;
	entry_t             rd_even, rd_odd;
	logic               odd_s1;

	assign we_even = wr_en & ~wr_index[0];
	assign we_odd  = wr_en & wr_index[0];

	// Entry i lives in bank i[0] at row i >> 1. For an odd first entry the even
	// neighbor sits one row up, wrapping from the last row to row zero.
	assign ra_half = rd_index[ADDR_W-1:1];
	assign ra_odd  = ra_half;
	assign ra_even = rd_index[0] ? ra_half + 1'b1 : ra_half;

	ptfi_ram #(.WIDTH(ENTRY_W), .DEPTH(BANK_DEPTH)) u_bank_even (
		.clk   (clk),
		.we    (we_even),
		.waddr (wr_index[ADDR_W-1:1]),
		.wdata (wr_entry),
		.re    (rd_en),
		.raddr (ra_even),
		.rdata (rd_even)
	);

	ptfi_ram #(.WIDTH(ENTRY_W), .DEPTH(BANK_DEPTH)) u_bank_odd (
		.clk   (clk),
		.we    (we_odd),
		.waddr (wr_index[ADDR_W-1:1]),
		.wdata (wr_entry),
		.re    (rd_en),
		.raddr (ra_odd),
		.rdata (rd_odd)
	);

	always_ff @(posedge clk) begin
		if (ctrl.load[0]) begin
			odd_s1 <= rd_index[0];
		end
	end

	assign ent0 = odd_s1 ? rd_odd : rd_even;
	assign ent1 = odd_s1 ? rd_even : rd_odd;

	// The table counts as loaded once its last entry has been written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded <= 1'b0;
		end else if (wr_en && (wr_index == ADDR_W'(TABLE_DEPTH - 1))) begin
			loaded <= 1'b1;
		end
	end

	a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en))
		else $error("table read and write issued in the same cycle");

	a_even_pair_same_row: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && !rd_index[0]) |-> (ra_even == ra_odd))
		else $error("even first entry must read both banks at one row");

	a_odd_pair_next_row: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && rd_index[0]) |-> (ra_even == ra_odd + 1'b1))
		else $error("odd first entry must read the even neighbor one row up");

endmodule

`default_nettype wire

FILE: design/ptfi_blend.sv
// Linear interpolation between two neighboring table entries over three
// pipeline stages: difference, product with the fraction, rounded sum.
// Uses ptfi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptfi_blend (
	input  wire logic                 clk,
	input  wire ptfi_pkg::pipe_ctrl_t ctrl,
	input  wire ptfi_pkg::entry_t     ent0,
	input  wire ptfi_pkg::entry_t     ent1,
	input  wire ptfi_pkg::side_t      side_s1,
	output ptfi_pkg::entry_t          blend_s4,
	output ptfi_pkg::side_t           side_s4
);
	import ptfi_pkg::*;

	localparam logic signed [50:0] HALF16_L = 51'sd32768;
	localparam logic signed [34:0] HALF16_C = 35'sd32768;

	logic        [31:0] a_s2 [NUM_LANES];
	logic signed [32:0] d_s2 [NUM_LANES];
	logic        [15:0] ca_s2;
	logic signed [16:0] cd_s2;
	side_t              side_s2;

	logic        [31:0] a_s3 [NUM_LANES];
	logic signed [49:0] p_s3 [NUM_LANES];
	logic        [15:0] ca_s3;
	logic signed [33:0] cp_s3;
	side_t              side_s3;

	logic signed [50:0] rs [NUM_LANES];
	logic signed [34:0] crs;

	always_ff @(posedge clk) begin
		if (ctrl.load[1]) begin
			for (int k = 0; k < NUM_LANES; k++) begin
				a_s2[k] <= ent0.lane[k];
				d_s2[k] <= 33'($signed(ent1.lane[k])) - 33'($signed(ent0.lane[k]));
			end
			ca_s2   <= ent0.conf;
			cd_s2   <= $signed({1'b0, ent1.conf}) - $signed({1'b0, ent0.conf});
			side_s2 <= side_s1;
		end
		if (ctrl.load[2]) begin
			for (int k = 0; k < NUM_LANES; k++) begin
				a_s3[k] <= a_s2[k];
				p_s3[k] <= 50'($signed({1'b0, side_s2.frac})) * 50'(d_s2[k]);
			end
			ca_s3   <= ca_s2;
			cp_s3   <= 34'($signed({1'b0, side_s2.frac})) * 34'(cd_s2);
			side_s3 <= side_s2;
		end
		if (ctrl.load[3]) begin
			// The blended value stays between the two entries, so the low bits
			// of the sum are the exact result.
			for (int k = 0; k < NUM_LANES; k++) begin
				blend_s4.lane[k] <= a_s3[k] + rs[k][31:0];
			end
			blend_s4.conf <= ca_s3 + crs[15:0];
			side_s4       <= side_s3;
		end
	end

	always_comb begin
		for (int k = 0; k < NUM_LANES; k++) begin
			rs[k] = (51'(p_s3[k]) + HALF16_L) >>> 16;
		end
		crs = (35'(cp_s3) + HALF16_C) >>> 16;
	end

endmodule

`default_nettype wire

FILE: design/ptfi_xform.sv
// Body-frame transform: yaw rotation and mount offset of the foot position,
// rate scaling and rotation of the slopes, saturation and the output register.
// Uses ptfi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptfi_xform (
	input  wire logic                 clk,
	input  wire ptfi_pkg::pipe_ctrl_t ctrl,
	input  wire ptfi_pkg::cfg_t       cfg,
	input  wire ptfi_pkg::entry_t     blend_s4,
	input  wire ptfi_pkg::side_t      side_s4,
	output logic signed [31:0]        foot_x_s8,
	output logic signed [31:0]        foot_y_s8,
	output logic signed [31:0]        foot_z_s8,
	output logic signed [31:0]        vel_x_s8,
	output logic signed [31:0]        vel_y_s8,
	output logic signed [31:0]        vel_z_s8,
	output logic        [15:0]        conf_s8,
	output logic                      rdy_s8
);
	import ptfi_pkg::*;

	localparam logic signed [48:0] HALF14_P = 49'sd8192;
	localparam logic signed [64:0] HALF16_V = 65'sd32768;
	localparam logic signed [64:0] HALF14_V = 65'sd8192;

	// Stage 5: first products.
	logic signed [47:0] pcx_s5, psx_s5;
	logic signed [63:0] pvx_s5, pvz_s5;
	logic signed [31:0] lz_s5;
	logic        [15:0] cf_s5;
	logic               rdy_s5;

	// Stage 6: positions done, x velocity kept wide before rotation.
	logic signed [31:0] fx_s6, fy_s6, fz_s6, vz_s6;
	logic signed [47:0] vx_s6;
	logic        [15:0] cf_s6;
	logic               rdy_s6;

	// Stage 7: rotated velocity products.
	logic signed [63:0] qcx_s7, qsx_s7;
	logic signed [31:0] fx_s7, fy_s7, fz_s7, vz_s7;
	logic        [15:0] cf_s7;
	logic               rdy_s7;

	logic signed [35:0] fx_sum, fy_sum;
	logic signed [32:0] fz_sum;
	logic signed [64:0] vx_rnd, vz_rnd, vcx_rnd, vsx_rnd;

	always_comb begin
		fx_sum  = 36'(cfg.mount_x) + 36'((49'(pcx_s5) + HALF14_P) >>> 14);
		fy_sum  = 36'(cfg.mount_y) + 36'((49'(psx_s5) + HALF14_P) >>> 14);
		fz_sum  = 33'(cfg.mount_z) + 33'(lz_s5);
		vx_rnd  = (65'(pvx_s5) + HALF16_V) >>> 16;
		vz_rnd  = (65'(pvz_s5) + HALF16_V) >>> 16;
		vcx_rnd = (65'(qcx_s7) + HALF14_V) >>> 14;
		vsx_rnd = (65'(qsx_s7) + HALF14_V) >>> 14;
	end

	always_ff @(posedge clk) begin
		if (ctrl.load[4]) begin
			pcx_s5 <= 48'(cfg.yaw_cos) * 48'($signed(blend_s4.lane[LANE_LX]));
			psx_s5 <= 48'(cfg.yaw_sin) * 48'($signed(blend_s4.lane[LANE_LX]));
			pvx_s5 <= 64'($signed(blend_s4.lane[LANE_SX])) * 64'(side_s4.rate);
			pvz_s5 <= 64'($signed(blend_s4.lane[LANE_SZ])) * 64'(side_s4.rate);
			lz_s5  <= $signed(blend_s4.lane[LANE_LZ]);
			cf_s5  <= blend_s4.conf;
			rdy_s5 <= side_s4.rdy;
		end
		if (ctrl.load[5]) begin
			fx_s6  <= sat32(66'(fx_sum));
			fy_s6  <= sat32(66'(fy_sum));
			fz_s6  <= sat32(66'(fz_sum));
			vx_s6  <= vx_rnd[47:0];
			vz_s6  <= sat32(66'(vz_rnd));
			cf_s6  <= cf_s5;
			rdy_s6 <= rdy_s5;
		end
		if (ctrl.load[6]) begin
			qcx_s7 <= 64'(cfg.yaw_cos) * 64'(vx_s6);
			qsx_s7 <= 64'(cfg.yaw_sin) * 64'(vx_s6);
			fx_s7  <= fx_s6;
			fy_s7  <= fy_s6;
			fz_s7  <= fz_s6;
			vz_s7  <= vz_s6;
			cf_s7  <= cf_s6;
			rdy_s7 <= rdy_s6;
		end
		if (ctrl.load[7]) begin
			// An unloaded table gives an all-zero result.
			if (rdy_s7) begin
				foot_x_s8 <= fx_s7;
				foot_y_s8 <= fy_s7;
				foot_z_s8 <= fz_s7;
				vel_x_s8  <= sat32(66'(vcx_rnd));
				vel_y_s8  <= sat32(66'(vsx_rnd));
				vel_z_s8  <= vz_s7;
				conf_s8   <= cf_s7;
			end else begin
				foot_x_s8 <= '0;
				foot_y_s8 <= '0;
				foot_z_s8 <= '0;
				vel_x_s8  <= '0;
				vel_y_s8  <= '0;
				vel_z_s8  <= '0;
				conf_s8   <= '0;
			end
			rdy_s8 <= rdy_s7;
		end
	end

endmodule

`default_nettype wire

FILE: design/phase_table_foot_interpolator.sv
// Phase table foot interpolator, top level. Uses ptfi_pkg, ptfi_table,
// ptfi_blend and ptfi_xform.
// Pipeline: eight register stages (table read, three blend, four transform); the first
// loads at the accepting edge.
// Throughput: one transaction per cycle while in_ready is high; writes take one slot, no result.
// Reset: arst_n clears pipeline valids, the table-loaded flag and the registers
// (yaw_cos to 1.0); table contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module phase_table_foot_interpolator (
	input  wire logic                           clk,
	input  wire logic                           arst_n,

	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [ptfi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                    cfg_data,

	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           operation,
	input  wire logic [15:0]                    phase_turn,
	input  wire logic signed [31:0]             phase_rate,
	input  wire logic [9:0]                     entry_index,
	input  wire logic signed [31:0]             entry_local_x,
	input  wire logic signed [31:0]             entry_local_z,
	input  wire logic signed [31:0]             entry_slope_x,
	input  wire logic signed [31:0]             entry_slope_z,
	input  wire logic [15:0]                    entry_confidence,

	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic signed [31:0]                  foot_x,
	output logic signed [31:0]                  foot_y,
	output logic signed [31:0]                  foot_z,
	output logic signed [31:0]                  vel_x,
	output logic signed [31:0]                  vel_y,
	output logic signed [31:0]                  vel_z,
	output logic [15:0]                         confidence,
	output logic                                valid_res
);
	import ptfi_pkg::*;

	// Configuration registers. The port never stalls; the user must send writes only while
	// the pipeline is empty (not enforced here), so every stage sees one stable set of values.
	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mount_x <= '0;
			cfg_q.mount_y <= '0;
			cfg_q.mount_z <= '0;
			cfg_q.yaw_cos <= YAW_COS_RESET;
			cfg_q.yaw_sin <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MOUNT_X: cfg_q.mount_x <= cfg_data;
				CFG_MOUNT_Y: cfg_q.mount_y <= cfg_data;
				CFG_MOUNT_Z: cfg_q.mount_z <= cfg_data;
				CFG_YAW_COS: cfg_q.yaw_cos <= cfg_data[15:0];
				CFG_YAW_SIN: cfg_q.yaw_sin <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Pipeline flow control. Each stage holds a valid bit and may load when it
	// is empty or when the stage after it moves on, so bubbles collapse and a
	// result waiting at the output does not block new transactions until the
	// pipeline is actually full. Write transactions only need stage 1 to be
	// free, which keeps table writes and reads in separate cycles.
	logic [NUM_STAGES-1:0] v_q;
	logic [NUM_STAGES-1:0] adv;
	pipe_ctrl_t            ctrl;
	logic                  accept, eval_acc, wr_acc;

	always_comb begin
		adv[NUM_STAGES-1] = ~v_q[NUM_STAGES-1] | out_ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			adv[k] = ~v_q[k] | adv[k+1];
		end
	end

	assign ctrl.load = adv;
	assign in_ready  = adv[0];
	assign accept    = in_valid & in_ready;
	assign eval_acc  = accept & ~operation;
	assign wr_acc    = accept & operation;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (adv[0]) begin
				v_q[0] <= eval_acc;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (adv[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	// Table access. The upper phase bits pick the first entry, the rest form
	// the Q0.16 fraction toward its neighbor.
	entry_t             wr_entry, ent0, ent1, blend_s4;
	logic               tbl_loaded;
	logic [ADDR_W-1:0]  rd_index;
	logic [PHASE_W-1:0] frac;
	side_t              side_s1, side_s4;

	assign wr_entry.lane[LANE_LX] = entry_local_x;
	assign wr_entry.lane[LANE_LZ] = entry_local_z;
	assign wr_entry.lane[LANE_SX] = entry_slope_x;
	assign wr_entry.lane[LANE_SZ] = entry_slope_z;
	assign wr_entry.conf          = entry_confidence;

	assign rd_index = phase_turn[PHASE_W-1 -: ADDR_W];
	assign frac     = {phase_turn[PHASE_W-ADDR_W-1:0], {ADDR_W{1'b0}}};

	ptfi_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.wr_en    (wr_acc),
		.wr_index (entry_index[ADDR_W-1:0]),
		.wr_entry (wr_entry),
		.rd_en    (eval_acc),
		.rd_index (rd_index),
		.ent0     (ent0),
		.ent1     (ent1),
		.loaded   (tbl_loaded)
	);

	// Side band for stage 1; the loaded flag is sampled with the transaction so
	// that writes accepted earlier are already reflected.
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			side_s1.frac <= frac;
			side_s1.rate <= phase_rate;
			side_s1.rdy  <= tbl_loaded;
		end
	end

	ptfi_blend u_blend (
		.clk      (clk),
		.ctrl     (ctrl),
		.ent0     (ent0),
		.ent1     (ent1),
		.side_s1  (side_s1),
		.blend_s4 (blend_s4),
		.side_s4  (side_s4)
	);

	ptfi_xform u_xform (
		.clk       (clk),
		.ctrl      (ctrl),
		.cfg       (cfg_q),
		.blend_s4  (blend_s4),
		.side_s4   (side_s4),
		.foot_x_s8 (foot_x),
		.foot_y_s8 (foot_y),
		.foot_z_s8 (foot_z),
		.vel_x_s8  (vel_x),
		.vel_y_s8  (vel_y),
		.vel_z_s8  (vel_z),
		.conf_s8   (confidence),
		.rdy_s8    (valid_res)
	);

	assign out_valid = v_q[NUM_STAGES-1];

	a_empty_pipe_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q == '0) |-> in_ready)
		else $error("empty pipeline refused a transaction");

	a_loaded_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(tbl_loaded))
		else $error("table loaded flag dropped without reset");

	a_unloaded_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !valid_res) |->
			(foot_x == 0 && foot_z == 0 && vel_x == 0 && vel_z == 0 && confidence == 0))
		else $error("result from an unloaded table is not all zero");

endmodule

`default_nettype wire
